>>> design/assert_macros.svh
// Assertion macros for the RTL of the encoder, included by the encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset is released.
`define B64XE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define B64XE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/b64xe_pkg.sv
// Types, constants and the alphabet mapping of the base64 XOR block encoder.
`default_nettype none

package b64xe_pkg;

    localparam int unsigned KEY_BYTES = 8;
    localparam int unsigned KEY_AW    = 3;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned SEXTET_W  = 6;
    localparam int unsigned POS_W     = 6;

    localparam logic [POS_W-1:0] LAST_POS = 6'd63;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } key_wr_t;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
    } key_rd_t;

    function automatic logic [CHAR_W-1:0] alphabet(input logic [SEXTET_W-1:0] c);
        logic [CHAR_W-1:0] cw;
        cw = {1'b0, c};
        case (c) inside
            [6'd0:6'd25]:  return cw + 7'h41;
            [6'd26:6'd51]: return cw + 7'd71;
            [6'd52:6'd61]: return cw - 7'd4;
            6'd62:         return 7'h2B;
            default:       return 7'h2F;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> design/b64xe_ifs.sv
// Valid/ready channel interfaces for bytes, characters and key writes.
`default_nettype none

interface b64xe_byte_if;
    logic                             valid;
    logic                             ready;
    logic [b64xe_pkg::BYTE_W-1:0]     data_byte;
    logic                             end_of_block;

    modport source (output valid, output data_byte, output end_of_block, input ready);
    modport sink   (input valid, input data_byte, input end_of_block, output ready);
endinterface

interface b64xe_char_if;
    logic                             valid;
    logic                             ready;
    logic [b64xe_pkg::CHAR_W-1:0]     out_char;
    logic                             last_of_block;

    modport source (output valid, output out_char, output last_of_block, input ready);
    modport sink   (input valid, input out_char, input last_of_block, output ready);
endinterface

interface b64xe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [b64xe_pkg::CFG_IDX_W-1:0]  index;
    logic [b64xe_pkg::BYTE_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/base64_xor_block_encoder_core.sv
// Top level of the base64 XOR block encoder: sequencer, key lookup and output register.
//
//  Channel   Dir   Payload                       Transfer
//  byte_ch   in    data_byte[7:0], end_of_block  valid & ready
//  char_ch   out   out_char[6:0], last_of_block  valid & ready
//  cfg_ch    in    index[3:0], data[7:0]         valid & ready (always ready)
//
// The next byte waits until this one's characters issue, two if it ends a group of three.
// Its first character goes through issue, key read and the output register before it can transfer.
// A closing byte pads with zeros up to character 63, one character a cycle unless stalled.
// Reset clears the sequencer, the pipeline valids and the key valid bits; keys read as zero.
// The output register holds under backpressure and stalls the key read stage behind it.
`default_nettype none

module base64_xor_block_encoder_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    b64xe_byte_if.sink     byte_ch,
    b64xe_char_if.source   char_ch,
    b64xe_cfg_if.sink      cfg_ch
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    state_t                               state_reg, state_next;
    logic [b64xe_pkg::POS_W-1:0]          char_pos_reg, char_pos_next;
    logic [b64xe_pkg::BYTE_W-1:0]         data_reg, data_next;
    logic [3:0]                           left_reg, left_next;
    logic                                 eob_reg, eob_next;

    logic                                 s1_vld_reg;
    logic [b64xe_pkg::SEXTET_W-1:0]       s1_sextet_reg;
    logic [b64xe_pkg::POS_W-1:0]          s1_pos_reg;

    logic                                 out_vld_reg;
    logic [b64xe_pkg::CHAR_W-1:0]         out_char_reg;
    logic                                 out_last_reg;

    logic                                 in_xfer;
    logic                                 out_adv;
    logic                                 s1_free;
    logic                                 issue;
    logic [1:0]                           ph;
    logic [b64xe_pkg::SEXTET_W-1:0]       sextet;
    b64xe_pkg::key_wr_t                   key_wr;
    b64xe_pkg::key_rd_t                   key_rd;
    logic [b64xe_pkg::BYTE_W-1:0]         key_byte;
    logic [2*b64xe_pkg::BYTE_W-1:0]       key_dbl;
    logic [b64xe_pkg::SEXTET_W-1:0]       key_word;
    logic [b64xe_pkg::SEXTET_W-1:0]       enc_val;

    assign byte_ch.ready = (state_reg == S_IDLE);
    assign in_xfer       = byte_ch.valid && byte_ch.ready;
    assign out_adv       = s1_vld_reg && (!out_vld_reg || char_ch.ready);
    assign s1_free       = !s1_vld_reg || out_adv;
    assign issue         = (state_reg == S_RUN) && s1_free;
    assign ph            = char_pos_reg[1:0];

    assign cfg_ch.ready = 1'b1;
    assign key_wr.en    = cfg_ch.valid && cfg_ch.ready
                          && (cfg_ch.index < b64xe_pkg::CFG_IDX_W'(b64xe_pkg::KEY_BYTES));
    assign key_wr.addr  = cfg_ch.index[b64xe_pkg::KEY_AW-1:0];
    assign key_wr.data  = cfg_ch.data;

    assign key_rd.en    = issue;
    assign key_rd.addr  = char_pos_reg[5:3] + char_pos_reg[2:0];

    b64xe_key_mem u_key_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (key_wr),
        .rd      (key_rd),
        .rd_data (key_byte)
    );

    always_comb
    begin
        case (ph)
            PH_A:    sextet = data_reg[7:2];
            PH_B:    sextet = {left_reg[1:0], data_reg[7:4]};
            PH_C:    sextet = {left_reg[3:0], data_reg[7:6]};
            default: sextet = data_reg[5:0];
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        char_pos_next = char_pos_reg;
        data_next     = data_reg;
        left_next     = left_reg;
        eob_next      = eob_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_RUN;
                    data_next  = byte_ch.data_byte;
                    eob_next   = byte_ch.end_of_block;
                end
            end
            S_RUN:
            begin
                if (issue)
                begin
                    char_pos_next = char_pos_reg + 6'd1;
                    left_next     = data_reg[3:0];
                    if (char_pos_reg == b64xe_pkg::LAST_POS)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (ph != PH_C)
                    begin
                        if (eob_reg)
                        begin
                            data_next = '0;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign key_dbl  = {key_byte, key_byte} << s1_pos_reg[5:3];
    assign key_word = key_dbl[b64xe_pkg::BYTE_W +: b64xe_pkg::SEXTET_W] ^ s1_pos_reg;
    assign enc_val  = s1_sextet_reg ^ key_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            char_pos_reg <= '0;
            s1_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            char_pos_reg <= char_pos_next;
            if (s1_free)
            begin
                s1_vld_reg <= issue;
            end
            if (out_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (char_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        left_reg <= left_next;
        eob_reg  <= eob_next;
        if (issue)
        begin
            s1_sextet_reg <= sextet;
            s1_pos_reg    <= char_pos_reg;
        end
        if (out_adv)
        begin
            out_char_reg <= b64xe_pkg::alphabet(enc_val);
            out_last_reg <= (s1_pos_reg == b64xe_pkg::LAST_POS);
        end
    end

    assign char_ch.valid         = out_vld_reg;
    assign char_ch.out_char      = out_char_reg;
    assign char_ch.last_of_block = out_last_reg;

    `B64XE_ASSERT(a_accept_starts_run, in_xfer |=> (state_reg == S_RUN), "accepted byte did not start a run")
    `B64XE_ASSERT(a_s1_holds, (s1_vld_reg && !out_adv) |=> (s1_vld_reg && $stable(s1_pos_reg)), "stalled key stage lost its character")
    `B64XE_ASSERT(a_block_wraps, (issue && (char_pos_reg == b64xe_pkg::LAST_POS)) |=> ((state_reg == S_IDLE) && (char_pos_reg == '0)), "block did not close after its last character")
    `B64XE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_vld_reg && !s1_vld_reg), "pipeline valid set during reset")

endmodule

`default_nettype wire

>>> design/b64xe_key_mem.sv
// Eight-entry key byte memory with registered read and per-entry valid bits.
`default_nettype none

module b64xe_key_mem (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire b64xe_pkg::key_wr_t            wr,
    input  wire b64xe_pkg::key_rd_t            rd,
    output logic [b64xe_pkg::BYTE_W-1:0]       rd_data
);

    logic [b64xe_pkg::BYTE_W-1:0]    mem [b64xe_pkg::KEY_BYTES];
    logic [b64xe_pkg::KEY_BYTES-1:0] vld_reg;
    logic [b64xe_pkg::BYTE_W-1:0]    rd_mem_reg;
    logic                            rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_mem_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_vld_reg <= vld_reg[rd.addr];
            end
        end
    end

    // An entry not written since reset reads as zero.
    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire

>>> verif/tb_base64_xor_block_encoder_core.sv
// Self-checking testbench for the base64 XOR block encoder core.
`timescale 1ns / 100ps

module tb_base64_xor_block_encoder_core;

    localparam int unsigned BLOCK_BYTES = 48;
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned DRAIN_TAIL  = 40;

    localparam logic [6:0] ASC_UPPER = 7'h41;
    localparam logic [6:0] ASC_LOWER = 7'h61;
    localparam logic [6:0] ASC_DIGIT = 7'h30;
    localparam logic [6:0] ASC_PLUS  = 7'h2B;
    localparam logic [6:0] ASC_SLASH = 7'h2F;

    typedef enum logic [b64xe_pkg::CFG_IDX_W-1:0] {
        KEY_BYTE_0, KEY_BYTE_1, KEY_BYTE_2, KEY_BYTE_3,
        KEY_BYTE_4, KEY_BYTE_5, KEY_BYTE_6, KEY_BYTE_7
    } key_reg_e;

    typedef struct packed {
        logic [b64xe_pkg::CHAR_W-1:0] ch;
        logic                         last;
    } enc_char_t;

    typedef logic [b64xe_pkg::BYTE_W-1:0] key_set_t [b64xe_pkg::KEY_BYTES];

    class char_predictor;
        logic [b64xe_pkg::BYTE_W-1:0] key_bytes [b64xe_pkg::KEY_BYTES];
        int unsigned                  byte_pos;
        logic [3:0]                   carry_bits;
        enc_char_t                    pending_chars [$];
        int unsigned                  errors;

        function new();
            foreach (key_bytes[k])
                key_bytes[k] = '0;
            byte_pos   = 0;
            carry_bits = '0;
            errors     = 0;
        endfunction

        function void write_key(key_reg_e idx, logic [b64xe_pkg::BYTE_W-1:0] val);
            key_bytes[int'(idx)] = val;
        endfunction

        function logic [b64xe_pkg::CHAR_W-1:0] to_ascii(logic [5:0] v);
            if (v < 6'd26)
                return ASC_UPPER + {1'b0, v};
            else if (v < 6'd52)
                return ASC_LOWER + ({1'b0, v} - 7'd26);
            else if (v < 6'd62)
                return ASC_DIGIT + ({1'b0, v} - 7'd52);
            else if (v == 6'd62)
                return ASC_PLUS;
            return ASC_SLASH;
        endfunction

        function void put_char(logic [5:0] sextet, logic [5:0] p);
            logic [2:0]  sel;
            logic [15:0] spread;
            logic [5:0]  kw;
            enc_char_t   c;
            sel    = p[5:3] + p[2:0];
            spread = {key_bytes[sel], key_bytes[sel]} << p[5:3];
            kw     = spread[13:8] ^ p;
            c.ch   = to_ascii(sextet ^ kw);
            c.last = (p == b64xe_pkg::LAST_POS);
            pending_chars.push_back(c);
        endfunction

        function void feed(logic [7:0] d);
            logic [5:0] base;
            base = 6'((byte_pos / 3) * 4);
            case (byte_pos % 3)
                0:
                begin
                    put_char(d[7:2], base);
                    carry_bits = {2'b00, d[1:0]};
                end
                1:
                begin
                    put_char({carry_bits[1:0], d[7:4]}, base + 6'd1);
                    carry_bits = d[3:0];
                end
                default:
                begin
                    put_char({carry_bits, d[7:6]}, base + 6'd2);
                    put_char(d[5:0], base + 6'd3);
                    carry_bits = '0;
                end
            endcase
            byte_pos++;
        endfunction

        function void note_byte(logic [7:0] d, logic close);
            if (byte_pos >= BLOCK_BYTES)
            begin
                byte_pos   = 0;
                carry_bits = '0;
                return;
            end
            feed(d);
            if (close || byte_pos >= BLOCK_BYTES)
            begin
                while (byte_pos < BLOCK_BYTES)
                    feed(8'h00);
                byte_pos   = 0;
                carry_bits = '0;
            end
        endfunction

        function void check_char(logic [b64xe_pkg::CHAR_W-1:0] ch, logic last);
            enc_char_t exp_c;
            if (pending_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected character, expected none, actual %h last %b",
                         $time, ch, last);
                return;
            end
            exp_c = pending_chars.pop_front();
            if (ch !== exp_c.ch)
            begin
                errors++;
                $display("%0t: out_char expected %h actual %h", $time, exp_c.ch, ch);
            end
            if (last !== exp_c.last)
            begin
                errors++;
                $display("%0t: last_of_block expected %b actual %b", $time, exp_c.last, last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    b64xe_byte_if byte_ch ();
    b64xe_char_if char_ch ();
    b64xe_cfg_if  cfg_ch ();

    base64_xor_block_encoder_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .char_ch (char_ch),
        .cfg_ch  (cfg_ch)
    );

    char_predictor tracker;
    int unsigned   tx_idle_pct;
    int unsigned   rx_idle_pct;
    int unsigned   rx_hold_len;
    int unsigned   rx_hold_left;
    int unsigned   quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                char_ch.ready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_hold_len > 0)
            begin
                rx_hold_left = rx_hold_len - 1;
                rx_hold_len  = 0;
                char_ch.ready <= 1'b0;
            end
            else
                char_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && char_ch.valid && char_ch.ready)
                tracker.check_char(char_ch.out_char, char_ch.last_of_block);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic close);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= d;
        byte_ch.end_of_block <= close;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        tracker.note_byte(d, close);
    endtask

    task automatic stop_bytes();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_bytes();
        while (tracker.pending_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_key(input key_reg_e idx, input logic [7:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        tracker.write_key(idx, val);
    endtask

    task automatic load_keys(input key_set_t kb);
        for (int k = 0; k < b64xe_pkg::KEY_BYTES; k++)
            write_key(key_reg_e'(k), kb[k]);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_keys();
        key_set_t kb;
        foreach (kb[k])
            kb[k] = rand_byte();
        load_keys(kb);
    endtask

    task automatic send_directed();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    // Mostly whole blocks of random length; a block cut by the item count runs on later.
    task automatic send_blocks(input int unsigned n_items);
        int unsigned left;
        int unsigned len;
        logic        cut;
        logic        close;
        left = n_items;
        while (left > 0)
        begin
            len = ($urandom_range(0, 3) == 0) ? BLOCK_BYTES : $urandom_range(1, BLOCK_BYTES - 1);
            cut = (len > left);
            if (cut)
                len = left;
            for (int unsigned k = 0; k < len; k++)
            begin
                close = !cut && (k == len - 1)
                        && (len < BLOCK_BYTES || $urandom_range(0, 1) == 1);
                send_byte(rand_byte(), close);
            end
            left -= len;
        end
    endtask

    initial
    begin
        key_set_t kb;
        tracker              = new();
        tx_idle_pct          = 13;
        rx_idle_pct          = 79;
        rx_hold_len          = 0;
        rx_hold_left         = 0;
        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = '0;
        byte_ch.end_of_block = 1'b0;
        char_ch.ready        = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_directed();
        wait_drained();
        foreach (kb[k])
            kb[k] = 8'hFF;
        load_keys(kb);
        send_directed();
        wait_drained();

        random_keys();
        tx_idle_pct = 13;
        rx_idle_pct = 79;
        send_blocks(30);
        rx_hold_len = 400;
        send_blocks(70);
        wait_drained();

        kb = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        load_keys(kb);
        tx_idle_pct = 79;
        rx_idle_pct = 13;
        send_blocks(100);
        wait_drained();

        random_keys();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_blocks(50);
        wait_drained();
        send_blocks(50);
        wait_drained();

        repeat (DRAIN_TAIL) @(posedge clk);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
